>>> hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: request and
// response beats, request and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 8;

	typedef enum logic [2:0] {
		REQ_INS_HEAD = 3'd0,
		REQ_INS_TAIL = 3'd1,
		REQ_INS_POS  = 3'd2,
		REQ_DEL_HEAD = 3'd3,
		REQ_DEL_TAIL = 3'd4,
		REQ_DEL_POS  = 3'd5,
		REQ_DUMP     = 3'd6
	} req_code_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_DUMP
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0]               req_type;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic                     has_value;
		logic                     last;
		logic [1:0]               status;
	} rsp_t;

	typedef struct packed {
		logic load_req;
		logic exec_op;
		logic dump_beat;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic dump_go;
		logic dump_last;
		logic list_empty;
	} dp_sts_t;

endpackage

>>> hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH signed 32-bit values with insert and delete
// requests at the head, the tail or a position, and a dump request.
// ----------------------------------------------------------------------------
// One request is taken at a time. For an insert, delete or empty dump the
// request is accepted, then executed in one execute step in which the
// element store shifts in place and the response is written; the next
// request is taken once the controller is back in idle. A dump of n elements
// is accepted, has an execute step that starts the stream, then sends one
// response beat per element as the store rotates by one cell per beat. Each
// beat goes through the single response register, so a stalled response side
// holds back the execute step and every beat.
module positional_list_engine #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ple_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ple_pkg::rsp_t rsp
);

	ple_pkg::dp_cmd_t cmd;
	ple_pkg::dp_sts_t sts;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ple_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> cmd.load_req)
		else $error("request beat accepted without loading the datapath");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second request taken while one is in flight");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dump_beat |-> !sts.list_empty)
		else $error("dump beat issued on an empty list");

	a_value_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.has_value) |-> (rsp.status == ple_pkg::ST_DONE))
		else $error("element beat carries an error status");

endmodule

>>> hw/rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: takes one request, has the datapath execute it, then,
// for a nonempty dump, streams dump beats until the last element has gone out.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ple_pkg::dp_sts_t  sts,
	output ple_pkg::dp_cmd_t  cmd
);

	ple_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ple_pkg::CS_IDLE: begin
				if (req_valid) state_nxt = ple_pkg::CS_EXEC;
			end
			ple_pkg::CS_EXEC: begin
				if (sts.out_free) state_nxt = sts.dump_go ? ple_pkg::CS_DUMP : ple_pkg::CS_IDLE;
			end
			ple_pkg::CS_DUMP: begin
				if (sts.out_free && sts.dump_last) state_nxt = ple_pkg::CS_IDLE;
			end
			default: state_nxt = ple_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		req_stall     = (state_q != ple_pkg::CS_IDLE);
		cmd.load_req  = (state_q == ple_pkg::CS_IDLE) && req_valid;
		cmd.exec_op   = (state_q == ple_pkg::CS_EXEC) && sts.out_free;
		cmd.dump_beat = (state_q == ple_pkg::CS_DUMP) && sts.out_free;
	end

endmodule

>>> hw/rtl/ple_datapath.sv
// ----------------------------------------------------------------------------
// ple_datapath
// Element store as a row of cells that shift in place, the request register,
// list length, dump counter and the response register.
// ----------------------------------------------------------------------------
module ple_datapath #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ple_pkg::req_t     req,
	input  ple_pkg::dp_cmd_t  cmd,
	output ple_pkg::dp_sts_t  sts,
	input  logic              rsp_stall,
	output logic              rsp_valid,
	output ple_pkg::rsp_t     rsp
);

	localparam int LW = $clog2(DEPTH + 1);
	localparam int PW = ple_pkg::POS_W;

	ple_pkg::req_t                    req_q;
	logic [LW-1:0]                    len_q;
	logic [LW-1:0]                    cnt_q;
	logic signed [ple_pkg::DATA_W-1:0] entry_q [DEPTH];
	ple_pkg::rsp_t                    rsp_q;
	logic                             rsp_valid_q;

	logic [PW-1:0] len_w;
	logic [PW-1:0] ins_pos;
	logic [PW-1:0] del_pos;
	logic          is_ins, is_del, is_dump;
	logic          full, del_ok;
	logic          do_ins, do_del, do_rot;
	logic          out_free;
	logic          exec_rsp;
	logic [1:0]    op_status;

	assign len_w   = PW'(len_q);
	assign full    = (len_w == PW'(DEPTH));
	assign is_ins  = (req_q.req_type == ple_pkg::REQ_INS_HEAD) ||
		(req_q.req_type == ple_pkg::REQ_INS_TAIL) || (req_q.req_type == ple_pkg::REQ_INS_POS);
	assign is_del  = (req_q.req_type == ple_pkg::REQ_DEL_HEAD) ||
		(req_q.req_type == ple_pkg::REQ_DEL_TAIL) || (req_q.req_type == ple_pkg::REQ_DEL_POS);
	assign is_dump = (req_q.req_type == ple_pkg::REQ_DUMP);

	// Clamp insert position to the tail; head and tail codes override it.
	always_comb begin
		ins_pos = (req_q.position > len_w) ? len_w : req_q.position;
		del_pos = req_q.position;
		if (req_q.req_type == ple_pkg::REQ_INS_HEAD) begin
			ins_pos = '0;
		end else if (req_q.req_type == ple_pkg::REQ_INS_TAIL) begin
			ins_pos = len_w;
		end
		if (req_q.req_type == ple_pkg::REQ_DEL_HEAD) begin
			del_pos = '0;
		end else if (req_q.req_type == ple_pkg::REQ_DEL_TAIL) begin
			del_pos = len_w - PW'(1);
		end
	end

	assign del_ok   = (len_w != '0) && (del_pos < len_w);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign do_ins   = cmd.exec_op && is_ins && !full;
	assign do_del   = cmd.exec_op && is_del && del_ok;
	assign do_rot   = cmd.dump_beat;
	assign exec_rsp = cmd.exec_op && !(is_dump && (len_q != '0));

	always_comb begin
		op_status = ple_pkg::ST_DONE;
		if (is_ins && full) begin
			op_status = ple_pkg::ST_FULL;
		end else if (is_del && !del_ok) begin
			op_status = ple_pkg::ST_EMPTY;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_ins) begin
				len_q <= len_q + LW'(1);
			end else if (do_del) begin
				len_q <= len_q - LW'(1);
			end
			if (cmd.load_req) begin
				cnt_q <= '0;
			end else if (do_rot) begin
				cnt_q <= cnt_q + LW'(1);
			end
		end
	end

	// Each cell sees only its neighbors, the head and the request value; a
	// dump rotates the occupied part left once per beat, so it ends back in place.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [PW-1:0] IDX  = PW'(i);
		localparam logic [PW-1:0] IDX1 = PW'(i + 1);
		logic signed [ple_pkg::DATA_W-1:0] from_lo, from_hi;

		if (i > 0) begin : g_lo
			assign from_lo = entry_q[i-1];
		end else begin : g_lo0
			assign from_lo = entry_q[i];
		end
		if (i < DEPTH - 1) begin : g_hi
			assign from_hi = entry_q[i+1];
		end else begin : g_hi0
			assign from_hi = entry_q[i];
		end

		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (IDX == ins_pos) begin
					entry_q[i] <= req_q.value;
				end else if ((IDX > ins_pos) && (IDX <= len_w)) begin
					entry_q[i] <= from_lo;
				end
			end else if (do_del) begin
				if ((IDX >= del_pos) && (IDX1 < len_w)) entry_q[i] <= from_hi;
			end else if (do_rot) begin
				if (IDX1 < len_w) begin
					entry_q[i] <= from_hi;
				end else if (IDX1 == len_w) begin
					entry_q[i] <= entry_q[0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_rsp) begin
			rsp_q.value_out <= '0;
			rsp_q.has_value <= 1'b0;
			rsp_q.last      <= 1'b1;
			rsp_q.status    <= op_status;
		end else if (do_rot) begin
			rsp_q.value_out <= entry_q[0];
			rsp_q.has_value <= 1'b1;
			rsp_q.last      <= sts.dump_last;
			rsp_q.status    <= ple_pkg::ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_rsp || do_rot) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.out_free   = out_free;
	assign sts.dump_go    = is_dump && (len_q != '0);
	assign sts.dump_last  = ((cnt_q + LW'(1)) == len_q);
	assign sts.list_empty = (len_q == '0);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
